>>> hdl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types, opcodes and constants for the SPI backup memory slave.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int unsigned MemAddrBits = 16;
  localparam int unsigned MemDepth    = 1 << MemAddrBits;
  localparam int unsigned AddrBits    = 24;

  // host opcodes seen while no command is active
  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_WRITE     = 8'h02;
  localparam logic [7:0] OP_READ      = 8'h03;
  localparam logic [7:0] OP_WR_DIS    = 8'h04;
  localparam logic [7:0] OP_RD_STATUS = 8'h05;
  localparam logic [7:0] OP_WR_EN     = 8'h06;
  localparam logic [7:0] OP_ID        = 8'h08;
  localparam logic [7:0] OP_WRITE_HI  = 8'h0A;
  localparam logic [7:0] OP_READ_HI   = 8'h0B;

  localparam logic [7:0] ID_REPLY     = 8'hAA;
  localparam logic [7:0] ERASED_BYTE  = 8'hFF;
  localparam logic [8:0] ONE_BYTE_MASK = 9'h1FF;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_RESP  = 2'd2
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // take the input word this cycle
    logic clr_en;  // step the erase sweep
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // erase sweep writes its last entry this cycle
  } dp_status_t;

  // address-width detection signature: 01 80 00 00
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h01;
      2'd1:    b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/sbm_ram.sv
// ----------------------------------------------------------------------------
// sbm_ram
// Generic single-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sbm_ctrl.sv
// ----------------------------------------------------------------------------
// sbm_ctrl
// Sequencer: erase sweep after reset, then one word in, one reply out.
// ----------------------------------------------------------------------------
module sbm_ctrl
  import sbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> hdl/sbm_datapath.sv
// ----------------------------------------------------------------------------
// sbm_datapath
// Command decode, address gathering, width detection and backup storage.
// ----------------------------------------------------------------------------
module sbm_datapath
  import sbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       action_i,
  input  logic [7:0] data_in_i,
  output logic [7:0] data_out_o,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o
);

  logic [1:0]             fixed_q;
  cmd_e                   cmd_q, cmd_d;
  logic                   wen_q, wen_d;
  logic [AddrBits-1:0]    addr_q, addr_d;
  logic [1:0]             seen_q, seen_d;
  logic [1:0]             det_q, det_d;
  logic                   detecting_q, detecting_d;
  logic [2:0]             bcnt_q, bcnt_d;
  logic [1:0]             blow_q, blow_d;
  logic                   sig_q, sig_d;
  logic [7:0]             reply_q, reply_d;
  logic                   from_ram_q, from_ram_d;
  logic [MemAddrBits-1:0] clr_cnt_q;

  logic [1:0]             width;
  logic                   is_det;
  logic [AddrBits-1:0]    eff_addr;
  logic [1:0]             det_w;
  logic                   mem_rd, mem_wr;
  logic                   ram_we;
  logic [MemAddrBits-1:0] ram_addr;
  logic [7:0]             ram_wdata;
  logic [7:0]             ram_rdata;

  assign width  = (fixed_q != 2'd0) ? fixed_q : det_q;
  assign is_det = detecting_q && (fixed_q == 2'd0);
  assign eff_addr = (width == 2'd1) ? {{(AddrBits-9){1'b0}}, addr_q[8:0] & ONE_BYTE_MASK}
                                    : addr_q;

  always_comb begin
    if (bcnt_q == 3'd4 && sig_q)  det_w = 2'd2;
    else if (bcnt_q <= 3'd2)      det_w = 2'd1;
    else if (bcnt_q == 3'd3)      det_w = 2'd2;
    else if (bcnt_q == 3'd4)      det_w = 2'd3;
    else                          det_w = blow_q;
  end

  always_comb begin
    cmd_d       = cmd_q;
    wen_d       = wen_q;
    addr_d      = addr_q;
    seen_d      = seen_q;
    det_d       = det_q;
    detecting_d = detecting_q;
    bcnt_d      = bcnt_q;
    blow_d      = blow_q;
    sig_d       = sig_q;
    reply_d     = reply_q;
    from_ram_d  = from_ram_q;
    mem_rd      = 1'b0;
    mem_wr      = 1'b0;

    if (cmd_i.accept) begin
      reply_d    = data_in_i;
      from_ram_d = 1'b0;
      if (action_i) begin
        reply_d = 8'h00;
        cmd_d   = CMD_NONE;
        if (is_det && bcnt_q != 3'd0) begin
          det_d       = det_w;
          detecting_d = 1'b0;
          bcnt_d      = 3'd0;
          blow_d      = 2'd0;
          sig_d       = 1'b1;
        end
      end else begin
        case (cmd_q)
          CMD_READ, CMD_WRITE: begin
            if (is_det) begin
              reply_d = 8'h00;
              if (bcnt_q < 3'd4 && data_in_i != sig_byte(bcnt_q[1:0])) sig_d = 1'b0;
              if (bcnt_q < 3'd5) bcnt_d = bcnt_q + 3'd1;
              blow_d = blow_q + 2'd1;
            end else if (seen_q < width) begin
              addr_d = {addr_q[AddrBits-9:0], data_in_i};
              seen_d = seen_q + 2'd1;
            end else begin
              addr_d = eff_addr + AddrBits'(1);
              if (cmd_q == CMD_READ) begin
                mem_rd     = 1'b1;
                from_ram_d = 1'b1;
              end else begin
                mem_wr = wen_q;
              end
            end
          end
          CMD_STATUS: begin
            reply_d = {6'd0, wen_q, 1'b0};
          end
          default: begin
            case (data_in_i)
              OP_ID:        reply_d = ID_REPLY;
              OP_WR_DIS:    wen_d = 1'b0;
              OP_WR_EN:     wen_d = 1'b1;
              OP_RD_STATUS: cmd_d = CMD_STATUS;
              OP_WRITE, OP_READ: begin
                cmd_d  = data_in_i[0] ? CMD_READ : CMD_WRITE;
                seen_d = 2'd0;
                addr_d = '0;
              end
              OP_WRITE_HI, OP_READ_HI: begin
                cmd_d   = data_in_i[0] ? CMD_READ : CMD_WRITE;
                reply_d = data_in_i[0] ? OP_READ : OP_WRITE;
                seen_d  = 2'd0;
                // one-byte parts: high opcode becomes address bit 8
                addr_d  = (width == 2'd1) ? AddrBits'(1) : '0;
              end
              default: reply_d = data_in_i;
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_q     <= 2'd0;
      cmd_q       <= CMD_NONE;
      wen_q       <= 1'b0;
      addr_q      <= '0;
      seen_q      <= 2'd0;
      det_q       <= 2'd0;
      detecting_q <= 1'b1;
      bcnt_q      <= 3'd0;
      blow_q      <= 2'd0;
      sig_q       <= 1'b1;
      from_ram_q  <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) fixed_q <= cfg_wdata_i;
      cmd_q       <= cmd_d;
      wen_q       <= wen_d;
      addr_q      <= addr_d;
      seen_q      <= seen_d;
      det_q       <= det_d;
      detecting_q <= detecting_d;
      bcnt_q      <= bcnt_d;
      blow_q      <= blow_d;
      sig_q       <= sig_d;
      from_ram_q  <= from_ram_d;
      if (cmd_i.clr_en) clr_cnt_q <= clr_cnt_q + MemAddrBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    reply_q <= reply_d;
  end

  assign status_o.clr_last = cmd_i.clr_en && (&clr_cnt_q);

  assign ram_we    = cmd_i.clr_en || mem_wr;
  assign ram_addr  = cmd_i.clr_en ? clr_cnt_q : eff_addr[MemAddrBits-1:0];
  assign ram_wdata = cmd_i.clr_en ? ERASED_BYTE : data_in_i;

  sbm_ram #(
    .Width (8),
    .Depth (MemDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (mem_rd),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // ram read data only moves on a read, so it holds while the reply is stalled
  assign data_out_o = from_ram_q ? ram_rdata : reply_q;

endmodule

>>> hdl/spi_backup_memory_slave.sv
// ----------------------------------------------------------------------------
// spi_backup_memory_slave
// Byte-serial SPI backup memory slave: opcode decode, address, storage.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_stall_o  action_i, data_in_i
//  out      out  out_valid_o/out_stall_i data_out_o
//  cfg      in   cfg_we_i               cfg_wdata_i (fixed_addr_bytes)
//
//  Each word is accepted, then the reply register is shown.
//  The storage port is single ported; reads land in its output register.
//  After reset an erase sweep fills all 65536 storage entries with 0xFF
//  (one entry per cycle); in_stall_o stays high meanwhile, cfg is taken.
//  While a reply waits on out_stall_i no new word is accepted.
// ----------------------------------------------------------------------------
module spi_backup_memory_slave
  import sbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] data_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  sbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  sbm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (action_i),
    .data_in_i   (data_in_i),
    .data_out_o  (data_out_o),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status)
  );

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.clr_en |-> in_stall_o)
    else $error("word accepted during erase sweep");

  a_accept_gives_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word produced no reply");

  a_one_word_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while reply pending");

  a_no_clear_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.accept |=> !dp_cmd.clr_en)
    else $error("erase sweep restarted after traffic");

endmodule
